### hdl/ksm_pkg.sv
// Shared types, command codes and default sizes for the key sequence matcher.
`default_nettype none

package ksm_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned MaxSequencesDef      = 16;
  localparam int unsigned MaxSequenceLengthDef = 8;
  localparam int unsigned KeyBitsDef           = 16;

  // Fixed field widths of the beats.
  localparam int unsigned CmdW      = 2;
  localparam int unsigned KeyCodeW  = 16;
  localparam int unsigned EntryIdxW = 4;
  localparam int unsigned EntryPosW = 3;
  localparam int unsigned WordW     = 16;
  localparam int unsigned CountW    = 5;
  localparam int unsigned ProgressW = 4;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_KEY  = 2'd0;
  localparam logic [CmdW-1:0] CMD_WORD = 2'd1;
  localparam logic [CmdW-1:0] CMD_LEN  = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]      cmd;
    logic [KeyCodeW-1:0]  key_code;
    logic                 is_repeat;
    logic [EntryIdxW-1:0] entry_index;
    logic [EntryPosW-1:0] entry_position;
    logic [WordW-1:0]     entry_word;
  } in_t;

  typedef struct packed {
    logic                 matched;
    logic [EntryIdxW-1:0] match_index;
    logic                 rejected;
    logic [ProgressW-1:0] progress;
  } out_t;

  // Table write broadcast to every cell.
  typedef struct packed {
    logic                 key_we;
    logic                 len_we;
    logic [EntryIdxW-1:0] index;
    logic [EntryPosW-1:0] position;
    logic [WordW-1:0]     word;
  } cell_wr_t;

  // Scan flags handed from one cell to the next.
  typedef struct packed {
    logic found;
    logic open;
  } run_flags_t;

endpackage : ksm_pkg

`default_nettype wire

### hdl/ksm_cell.sv
// One matcher cell: holds one table entry and advances the range scan by one entry.
`default_nettype none

module ksm_cell #(
  parameter int unsigned MAX_SEQUENCES       = ksm_pkg::MaxSequencesDef,
  parameter int unsigned MAX_SEQUENCE_LENGTH = ksm_pkg::MaxSequenceLengthDef,
  parameter int unsigned KEY_BITS            = ksm_pkg::KeyBitsDef,
  parameter int unsigned CELL_INDEX          = 0,
  localparam int unsigned IdxW = $clog2(MAX_SEQUENCES),
  localparam int unsigned PosW = $clog2(MAX_SEQUENCE_LENGTH + 1)
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire ksm_pkg::cell_wr_t     wr_i,
  input  wire [KEY_BITS-1:0]         key_i,
  input  wire [PosW-1:0]             pos_i,
  input  wire [IdxW-1:0]             lo_i,
  input  wire [IdxW-1:0]             hi_i,
  input  wire ksm_pkg::run_flags_t   prev_flags_i,
  input  wire [IdxW-1:0]             prev_first_i,
  input  wire [IdxW-1:0]             prev_last_i,
  input  wire [PosW-1:0]             prev_len_i,
  output ksm_pkg::run_flags_t        flags_o,
  output logic [IdxW-1:0]            first_o,
  output logic [IdxW-1:0]            last_o,
  output logic [PosW-1:0]            len_o
);
  import ksm_pkg::*;

  localparam int unsigned AddrW = (MAX_SEQUENCE_LENGTH > 1) ? $clog2(MAX_SEQUENCE_LENGTH) : 1;
  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_INDEX);

  logic [KEY_BITS-1:0]   mem [MAX_SEQUENCE_LENGTH];
  logic [KEY_BITS-1:0]   rdata_q;
  logic [PosW-1:0]       len_q;
  logic [KEY_BITS+WordW-1:0]  word_ext;
  logic [AddrW+EntryPosW-1:0] waddr_ext;
  logic [AddrW+PosW-1:0]      raddr_ext;
  logic                  sel;
  logic                  key_we;
  logic                  len_we;
  logic                  in_range;
  logic                  hit;
  logic [PosW-1:0]       len_sat;

  run_flags_t            flags_d, flags_q;
  logic [IdxW-1:0]       first_d, first_q, last_d, last_q;
  logic [PosW-1:0]       len_d, len_out_q;

  assign word_ext  = {{KEY_BITS{1'b0}}, wr_i.word};
  assign waddr_ext = {{AddrW{1'b0}}, wr_i.position};
  assign raddr_ext = {{AddrW{1'b0}}, pos_i};

  assign sel    = (32'(wr_i.index) == 32'(CELL_INDEX));
  assign key_we = wr_i.key_we && sel && (32'(wr_i.position) < MAX_SEQUENCE_LENGTH);
  assign len_we = wr_i.len_we && sel;
  assign len_sat = (wr_i.word > WordW'(MAX_SEQUENCE_LENGTH)) ? PosW'(MAX_SEQUENCE_LENGTH)
                                                            : wr_i.word[PosW-1:0];

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      mem[waddr_ext[AddrW-1:0]] <= word_ext[KEY_BITS-1:0];
    end
    rdata_q <= mem[raddr_ext[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_q <= len_sat;
    end
  end

  // A position at or past the entry length never matches.
  assign in_range = (MyIdx >= lo_i) && (MyIdx <= hi_i);
  assign hit      = in_range && (pos_i < len_q) && (rdata_q == key_i);

  always_comb begin
    flags_d = prev_flags_i;
    first_d = prev_first_i;
    last_d  = prev_last_i;
    len_d   = prev_len_i;
    if (!prev_flags_i.found) begin
      if (hit) begin
        flags_d.found = 1'b1;
        flags_d.open  = 1'b1;
        first_d       = MyIdx;
        last_d        = MyIdx;
        len_d         = len_q;
      end
    end else if (prev_flags_i.open) begin
      if (hit) begin
        last_d = MyIdx;
      end else begin
        flags_d.open = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q   <= first_d;
    last_q    <= last_d;
    len_out_q <= len_d;
  end

  assign flags_o = flags_q;
  assign first_o = first_q;
  assign last_o  = last_q;
  assign len_o   = len_out_q;

endmodule : ksm_cell

`default_nettype wire

### hdl/key_sequence_matcher.sv
// Top level of the key sequence matcher: control, matcher state and the row of entry cells.
//
// Usage. Input beats arrive on in_valid_i/in_ready_o carrying ksm_pkg::in_t. A command
// either writes a key word or a length into the table, or presents a key event. Every
// input beat yields exactly one result beat on out_valid_o/out_ready_i carrying
// ksm_pkg::out_t: matched with the entry index, rejected, and the progress count.
// The user writes the sequence_count register on cfg_valid_i/cfg_ready_o only while the
// block is idle; the block does not enforce it. A write clamps the value to 1..MAX_SEQUENCES
// and restarts the matcher. The result of a table write, a repeat event or an unknown
// command goes from the result register into the output register. A key event first
// scans: the scan ripples down the row of cells, the finish state updates the range, and
// the result state loads the output register; the length of the cell row sets how long the
// scan takes. One item is worked on at a time; the next beat is accepted once the result
// sits in the output register, even while the receiver has not yet taken it.
// Reset. The matcher restarts with one entry in use and position zero; the table
// contents are undefined until written. If the receiver stalls, a finished result waits
// in the output register and the following result waits in the block until it drains.
`default_nettype none

module key_sequence_matcher #(
  parameter int unsigned MAX_SEQUENCES       = ksm_pkg::MaxSequencesDef,
  parameter int unsigned MAX_SEQUENCE_LENGTH = ksm_pkg::MaxSequenceLengthDef,
  parameter int unsigned KEY_BITS            = ksm_pkg::KeyBitsDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire ksm_pkg::in_t                in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output ksm_pkg::out_t                    out_data_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [ksm_pkg::CountW-1:0]        cfg_data_i
);
  import ksm_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_SEQUENCES);
  localparam int unsigned PosW = $clog2(MAX_SEQUENCE_LENGTH + 1);
  localparam int unsigned CntW = $clog2(MAX_SEQUENCES + 1);
  localparam logic [IdxW-1:0] ScanLast = IdxW'(MAX_SEQUENCES - 1);

  // Controller states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [IdxW-1:0]     scan_cnt_q, scan_cnt_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  out_t                res_q, res_d;
  out_t                out_q;
  logic                out_valid_q;

  logic                in_fire;
  logic                cfg_fire;
  logic                key_event;
  logic [KEY_BITS+KeyCodeW-1:0] key_ext;
  logic [IdxW-1:0]     last_entry;
  logic [IdxW-1:0]     hi_eff;
  logic [IdxW-1:0]     restart_hi;
  logic [CntW-1:0]     cfg_count;
  logic [PosW-1:0]     pos_inc;
  logic [ProgressW+PosW-1:0] prog_ext;
  logic [EntryIdxW+IdxW-1:0] idx_ext;
  logic                out_free;
  cell_wr_t            wr;

  run_flags_t          flags_w [MAX_SEQUENCES+1];
  logic [IdxW-1:0]     first_w [MAX_SEQUENCES+1];
  logic [IdxW-1:0]     last_w  [MAX_SEQUENCES+1];
  logic [PosW-1:0]     len_w   [MAX_SEQUENCES+1];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign key_event   = (in_data_i.cmd == CMD_KEY) && !in_data_i.is_repeat;
  assign out_free    = !out_valid_q || out_ready_i;

  // Only the low KEY_BITS bits of a key code take part in the comparison.
  assign key_ext = {{KEY_BITS{1'b0}}, in_data_i.key_code};

  // The scan never goes past the last entry in use.
  assign last_entry = IdxW'(count_q - 1'b1);
  assign hi_eff     = (hi_q > last_entry) ? last_entry : hi_q;
  assign restart_hi = last_entry;

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_count = CntW'(1);
    end else if (32'(cfg_data_i) > MAX_SEQUENCES) begin
      cfg_count = CntW'(MAX_SEQUENCES);
    end else begin
      cfg_count = CntW'(cfg_data_i);
    end
  end

  // Table writes go straight to the cells on the accepting edge.
  always_comb begin
    wr.key_we   = in_fire && (in_data_i.cmd == CMD_WORD);
    wr.len_we   = in_fire && (in_data_i.cmd == CMD_LEN);
    wr.index    = in_data_i.entry_index;
    wr.position = in_data_i.entry_position;
    wr.word     = in_data_i.entry_word;
  end

  // The head of the row sees an empty scan.
  assign flags_w[0] = '0;
  assign first_w[0] = '0;
  assign last_w[0]  = '0;
  assign len_w[0]   = '0;

  for (genvar k = 0; k < MAX_SEQUENCES; k++) begin : g_cell
    ksm_cell #(
      .MAX_SEQUENCES      (MAX_SEQUENCES),
      .MAX_SEQUENCE_LENGTH(MAX_SEQUENCE_LENGTH),
      .KEY_BITS           (KEY_BITS),
      .CELL_INDEX         (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_i        (wr),
      .key_i       (key_q),
      .pos_i       (pos_q),
      .lo_i        (lo_q),
      .hi_i        (hi_eff),
      .prev_flags_i(flags_w[k]),
      .prev_first_i(first_w[k]),
      .prev_last_i (last_w[k]),
      .prev_len_i  (len_w[k]),
      .flags_o     (flags_w[k+1]),
      .first_o     (first_w[k+1]),
      .last_o      (last_w[k+1]),
      .len_o       (len_w[k+1])
    );
  end

  assign pos_inc = pos_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    count_d    = count_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    pos_d      = pos_q;
    key_d      = key_q;
    res_d      = res_q;
    prog_ext   = '0;
    idx_ext    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (key_event) begin
            key_d      = key_ext[KEY_BITS-1:0];
            scan_cnt_d = '0;
            state_d    = ST_SCAN;
          end else begin
            // Writes, repeats and unknown commands leave the matcher alone.
            prog_ext          = {{ProgressW{1'b0}}, pos_q};
            res_d.matched     = 1'b0;
            res_d.match_index = '0;
            res_d.rejected    = 1'b0;
            res_d.progress    = prog_ext[ProgressW-1:0];
            state_d           = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        scan_cnt_d = scan_cnt_q + 1'b1;
        if (scan_cnt_q == ScanLast) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res_d.matched     = 1'b0;
        res_d.match_index = '0;
        res_d.rejected    = 1'b0;
        res_d.progress    = '0;
        if (!flags_w[MAX_SEQUENCES].found) begin
          res_d.rejected = 1'b1;
          lo_d           = '0;
          hi_d           = restart_hi;
          pos_d          = '0;
        end else if ((first_w[MAX_SEQUENCES] == last_w[MAX_SEQUENCES]) &&
                     ({1'b0, pos_inc} == {1'b0, len_w[MAX_SEQUENCES]})) begin
          idx_ext           = {{EntryIdxW{1'b0}}, first_w[MAX_SEQUENCES]};
          res_d.matched     = 1'b1;
          res_d.match_index = idx_ext[EntryIdxW-1:0];
          lo_d              = '0;
          hi_d              = restart_hi;
          pos_d             = '0;
        end else begin
          prog_ext       = {{ProgressW{1'b0}}, pos_inc};
          res_d.progress = prog_ext[ProgressW-1:0];
          lo_d           = first_w[MAX_SEQUENCES];
          hi_d           = last_w[MAX_SEQUENCES];
          pos_d          = pos_inc;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A count write restarts the matcher.
    if (cfg_fire) begin
      count_d = cfg_count;
      lo_d    = '0;
      hi_d    = IdxW'(cfg_count - 1'b1);
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_cnt_q  <= '0;
      count_q     <= CntW'(1);
      lo_q        <= '0;
      hi_q        <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      count_q    <= count_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      pos_q      <= pos_d;
      if ((state_q == ST_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    res_q <= res_d;
    if ((state_q == ST_RESULT) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The candidate range is never inverted between items.
  a_range_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (lo_q <= hi_q))
    else $error("candidate range inverted");

  // The position never runs past the longest sequence.
  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(pos_q) <= MAX_SEQUENCE_LENGTH))
    else $error("match position out of bounds");

  // A match or a reject always leaves the matcher at its start.
  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.matched || out_data_o.rejected)) |->
      (!(out_data_o.matched && out_data_o.rejected) && (out_data_o.progress == '0)))
    else $error("result flags inconsistent");

  // The range update only follows a full pass down the cell row.
  a_finish_after_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> ($past(state_q) == ST_SCAN) && ($past(scan_cnt_q) == ScanLast))
    else $error("range update without a full scan");

endmodule : key_sequence_matcher

`default_nettype wire

### dv/ksm_checker.sv
`timescale 1ns / 1ps
// Checker for the key sequence matcher: follows every handshake, predicts each result and compares.
module ksm_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  ksm_pkg::in_t                in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  ksm_pkg::out_t               out_data_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [ksm_pkg::CountW-1:0]  cfg_data_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 outstanding_o
);
  import ksm_pkg::*;

  localparam int unsigned Entries = MaxSequencesDef;
  localparam int unsigned Depth   = MaxSequenceLengthDef;

  // Private copy of the table and of the matcher state.
  logic [WordW-1:0]     key_words [Entries*Depth];
  logic [ProgressW-1:0] entry_len [Entries];
  int unsigned          live_count;
  int unsigned          cand_lo;
  int unsigned          cand_hi;
  int unsigned          key_pos;

  out_t awaited_outcomes [$];

  function automatic void restart_scan();
    cand_lo = 0;
    cand_hi = live_count - 1;
    key_pos = 0;
  endfunction

  // A position at or past the entry's length never matches.
  function automatic bit key_hit(int unsigned e, logic [KeyCodeW-1:0] k);
    if (e >= Entries || key_pos >= Depth) return 1'b0;
    if (key_pos >= entry_len[e]) return 1'b0;
    return key_words[e*Depth + key_pos] == k;
  endfunction

  function automatic out_t match_outcome(in_t beat);
    out_t        res;
    int unsigned last;
    int unsigned stop;
    int unsigned lo;
    int unsigned up;
    bit          hit;
    res = '0;
    case (beat.cmd)
      CMD_WORD: begin
        key_words[beat.entry_index*Depth + beat.entry_position] = beat.entry_word;
      end
      CMD_LEN: begin
        entry_len[beat.entry_index] =
          ProgressW'((beat.entry_word > Depth) ? Depth : beat.entry_word);
      end
      CMD_KEY: begin
        if (!beat.is_repeat) begin
          last = live_count - 1;
          stop = (cand_hi > last) ? last : cand_hi;
          lo   = cand_lo;
          hit  = 1'b0;
          while (!hit && lo <= stop) begin
            if (key_hit(lo, beat.key_code)) hit = 1'b1;
            else lo++;
          end
          if (!hit) begin
            res.rejected = 1'b1;
            restart_scan();
          end else begin
            up = lo;
            while (up < stop && key_hit(up + 1, beat.key_code)) up++;
            cand_lo = lo;
            cand_hi = up;
            if (lo == up && key_pos + 1 == entry_len[lo]) begin
              res.matched     = 1'b1;
              res.match_index = EntryIdxW'(lo);
              restart_scan();
            end else begin
              key_pos++;
            end
          end
        end
      end
      default: ;
    endcase
    res.progress = ProgressW'(key_pos);
    return res;
  endfunction

  // The result beat is compared before the new input beat is predicted, so that an
  // empty queue is never filled by the beat that is only just being accepted.
  always @(posedge clk_i) begin : observe
    out_t want;
    if (!rst_ni) begin
      live_count = 1;
      restart_scan();
      awaited_outcomes.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result beat arrived with no result awaited");
          fail_count_o++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (out_data_i.matched !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, out_data_i.matched);
            fail_count_o++;
          end
          if (out_data_i.match_index !== want.match_index) begin
            $error("match_index: expected %0d, actual %0d", want.match_index,
                   out_data_i.match_index);
            fail_count_o++;
          end
          if (out_data_i.rejected !== want.rejected) begin
            $error("rejected: expected %0d, actual %0d", want.rejected, out_data_i.rejected);
            fail_count_o++;
          end
          if (out_data_i.progress !== want.progress) begin
            $error("progress: expected %0d, actual %0d", want.progress, out_data_i.progress);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        live_count = (cfg_data_i == 0) ? 1 : (cfg_data_i > Entries) ? Entries : cfg_data_i;
        restart_scan();
      end
      if (in_valid_i && in_ready_i) awaited_outcomes.push_back(match_outcome(in_data_i));
      outstanding_o = awaited_outcomes.size();
    end
  end

endmodule

### dv/key_sequence_matcher_tb.sv
`timescale 1ns / 1ps
// Testbench top for the key sequence matcher: stimulus, receiver back-pressure and the verdict.
module key_sequence_matcher_tb;
  import ksm_pkg::*;

  // The fourth command code has no meaning to the block; it must be answered and ignored.
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  localparam int unsigned Entries      = MaxSequencesDef;
  localparam int unsigned Depth        = MaxSequenceLengthDef;
  localparam int unsigned PhaseBeats   = 50;
  localparam int unsigned LongHold     = 90;
  localparam int unsigned SettleCycles = 40;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CountW-1:0]   cfg_data;
  int unsigned         fail_count;
  int unsigned         outstanding;

  // quiet switches all idling off for the closing phase; stall_long asks the receiver
  // for one long hold-off so that the block fills up and stalls its input.
  bit                  quiet;
  bit                  stall_long;

  // Shadow of what has been written into the table, used only to shape the stimulus:
  // well-formed sequences follow it, and keys that miss every entry are drawn against it.
  logic [WordW-1:0]    shadow_words [Entries*Depth];
  int unsigned         shadow_len [Entries];
  int unsigned         live_entries;
  int unsigned         beats_sent;

  key_sequence_matcher dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  ksm_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: ready comes in random stretches, with random bursts held low,
  // one long hold-off on request, and no idling at all once the run goes quiet.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (stall_long) begin
        out_ready = 1'b0;
        repeat (LongHold) @(negedge clk);
        stall_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // Every field is randomised, so that the fields a command ignores still toggle.
  function automatic in_t random_beat(logic [CmdW-1:0] c);
    in_t b;
    b.cmd            = c;
    b.key_code       = KeyCodeW'($urandom_range(0, 65535));
    b.is_repeat      = 1'($urandom_range(0, 1));
    b.entry_index    = EntryIdxW'($urandom_range(0, Entries - 1));
    b.entry_position = EntryPosW'($urandom_range(0, Depth - 1));
    b.entry_word     = WordW'($urandom_range(0, 65535));
    return b;
  endfunction

  // Offers one beat and returns at the rising edge that accepts it. The sender may first
  // idle for a burst; valid stays high from the offer until acceptance.
  task automatic put_item(in_t beat);
    int unsigned gap;
    if (!quiet && !stall_long && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = beat;
    do @(posedge clk); while (!in_ready);
    if (!(beat.cmd == CmdUnused || (beat.cmd == CMD_KEY && beat.is_repeat))) beats_sent++;
  endtask

  task automatic send_key(logic [KeyCodeW-1:0] k, logic rep);
    in_t b;
    b           = random_beat(CMD_KEY);
    b.key_code  = k;
    b.is_repeat = rep;
    put_item(b);
  endtask

  task automatic send_word(int unsigned e, int unsigned p, logic [WordW-1:0] w);
    in_t b;
    b                = random_beat(CMD_WORD);
    b.entry_index    = EntryIdxW'(e);
    b.entry_position = EntryPosW'(p);
    b.entry_word     = w;
    shadow_words[e*Depth + p] = w;
    put_item(b);
  endtask

  task automatic send_len(int unsigned e, logic [WordW-1:0] w);
    in_t b;
    b             = random_beat(CMD_LEN);
    b.entry_index = EntryIdxW'(e);
    b.entry_word  = w;
    shadow_len[e] = (w > Depth) ? Depth : w;
    put_item(b);
  endtask

  // Drops valid and waits until every awaited result has been taken by the receiver.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // The count register is only written with the block idle; the write restarts the matcher.
  task automatic write_count(logic [CountW-1:0] v);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    live_entries = (v == 0) ? 1 : (v > Entries) ? Entries : v;
  endtask

  // Builds a lexicographically sorted set of n entries over a small alphabet, so that
  // entries share prefixes and the candidate range narrows over several keys. Some
  // entries are copies of their neighbour. With full set, every word of every entry is
  // written, and the last two entries become identical runs of all-ones keys.
  task automatic load_table(int unsigned n, bit full);
    logic [WordW-1:0] alpha [3];
    logic [WordW-1:0] row [Entries][Depth];
    int unsigned      len [Entries];
    logic [WordW-1:0] tw;
    int unsigned      tl;
    int unsigned      a;
    int unsigned      b;
    int unsigned      p;
    bit               later;
    bit               decided;
    for (a = 0; a < 3; a++) alpha[a] = WordW'($urandom_range(0, 65535));
    for (a = 0; a < n; a++) begin
      len[a] = $urandom_range(1, $urandom_range(1, Depth));
      for (p = 0; p < Depth; p++) begin
        if ($urandom_range(0, 7) == 0) row[a][p] = WordW'($urandom_range(0, 65535));
        else row[a][p] = alpha[$urandom_range(0, 2)];
      end
      if (a > 0 && $urandom_range(0, 9) == 0) begin
        len[a] = len[a-1];
        for (p = 0; p < Depth; p++) row[a][p] = row[a-1][p];
      end
    end
    // Bubble sort: a shorter entry that is a prefix of a longer one goes first.
    for (a = 0; a + 1 < n; a++) begin
      for (b = 0; b + 1 < n - a; b++) begin
        later   = len[b] > len[b+1];
        decided = 1'b0;
        for (p = 0; p < Depth; p++) begin
          if (!decided && p < len[b] && p < len[b+1] && row[b][p] != row[b+1][p]) begin
            later   = row[b][p] > row[b+1][p];
            decided = 1'b1;
          end
        end
        if (later) begin
          for (p = 0; p < Depth; p++) begin
            tw          = row[b][p];
            row[b][p]   = row[b+1][p];
            row[b+1][p] = tw;
          end
          tl       = len[b];
          len[b]   = len[b+1];
          len[b+1] = tl;
        end
      end
    end
    // A run of all-ones keys at full length sorts after everything else.
    if (full) begin
      for (a = Entries - 2; a < Entries; a++) begin
        len[a] = Depth;
        for (p = 0; p < Depth; p++) row[a][p] = '1;
      end
    end
    for (a = 0; a < n; a++) begin
      for (p = 0; p < (full ? Depth : len[a]); p++) send_word(a, p, row[a][p]);
      // A full-length entry is sometimes given an oversized length, which saturates.
      if (len[a] == Depth && $urandom_range(0, 1) == 1)
        send_len(a, WordW'($urandom_range(Depth + 1, 65535)));
      else send_len(a, WordW'(len[a]));
    end
  endtask

  // A key that equals no word anywhere in the table is rejected from any state, which
  // brings the matcher back to position zero with the full range.
  task automatic unmatched_key();
    logic [KeyCodeW-1:0] k;
    bit                  clash;
    int unsigned         a;
    do begin
      k     = KeyCodeW'($urandom_range(0, 65535));
      clash = 1'b0;
      for (a = 0; a < Entries*Depth; a++) if (shadow_words[a] == k) clash = 1'b1;
    end while (clash);
    send_key(k, 1'b0);
  endtask

  // Plays the keys of one entry in order, with the odd auto-repeat mixed in and now and
  // then a stray key that breaks the sequence off.
  task automatic enter_sequence(int unsigned e);
    int unsigned p;
    bit          broken;
    broken = 1'b0;
    for (p = 0; p < shadow_len[e] && !broken; p++) begin
      if ($urandom_range(0, 11) == 0) send_key(KeyCodeW'($urandom_range(0, 65535)), 1'b1);
      if ($urandom_range(0, 19) == 0) begin
        send_key(shadow_words[$urandom_range(0, Entries*Depth - 1)], 1'b0);
        broken = 1'b1;
      end else begin
        send_key(shadow_words[e*Depth + p], 1'b0);
      end
    end
  endtask

  // Mostly well-formed sequences against entries in use; the rest is loose keys,
  // repeats, unused commands and stray table writes.
  task automatic random_traffic(int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned e;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 2) == 0) unmatched_key();
        e = $urandom_range(0, live_entries - 1);
        if (shadow_len[e] == 0) send_key(shadow_words[e*Depth], 1'b0);
        else enter_sequence(e);
      end else if (pick < 85) begin
        if ($urandom_range(0, 1) == 1)
          send_key(shadow_words[$urandom_range(0, Entries*Depth - 1)], $urandom_range(0, 3) == 0);
        else
          send_key(KeyCodeW'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
      end else if (pick < 92) begin
        put_item(random_beat(CmdUnused));
      end else if (pick < 96) begin
        send_word($urandom_range(0, Entries - 1), $urandom_range(0, Depth - 1),
                  WordW'($urandom_range(0, 65535)));
      end else begin
        if ($urandom_range(0, 1) == 1)
          send_len($urandom_range(0, Entries - 1), WordW'($urandom_range(0, Depth)));
        else send_len($urandom_range(0, Entries - 1), WordW'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    logic [CountW-1:0] plan [6];
    int unsigned       p;
    int unsigned       ph;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    quiet        = 1'b0;
    stall_long   = 1'b0;
    live_entries = 1;
    beats_sent   = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. The whole table is written first, so that no entry is ever read
    // before it holds a value. The count is still at its reset value of one here.
    load_table(Entries, 1'b1);
    // A count of zero clamps to one: only the first entry takes part.
    write_count(5'd0);
    for (p = 0; p < shadow_len[0]; p++) send_key(shadow_words[p], 1'b0);
    // Anything above the table size clamps to the full table.
    write_count(5'd31);
    // Two identical entries of full length: eight all-ones keys leave both as candidates
    // at the last position, and the ninth key is rejected.
    for (p = 0; p <= Depth; p++) send_key('1, 1'b0);
    send_key('0, 1'b0);
    send_key('1, 1'b1);
    put_item(random_beat(CmdUnused));
    // Saturating length, and a zero length that makes an entry unmatchable.
    send_len(Entries - 1, '1);
    send_len(Entries - 3, '0);
    unmatched_key();
    send_key(shadow_words[(Entries - 3)*Depth], 1'b0);
    send_word(Entries - 1, Depth - 1, '0);
    send_word(0, 0, '1);

    // Random phases, each with its own count and a freshly sorted table. The receiver
    // holds off for a long stretch early on; the closing phase runs with no idling.
    plan = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd16, 5'd16};
    plan[4] = CountW'($urandom_range(3, Entries - 1));
    for (ph = 0; ph < 6; ph++) begin
      if (ph == 5) quiet = 1'b1;
      write_count(plan[ph]);
      load_table(live_entries, 1'b0);
      if (ph == 0) stall_long = 1'b1;
      random_traffic(PhaseBeats);
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
hdl/ksm_pkg.sv
hdl/ksm_cell.sv
hdl/key_sequence_matcher.sv
dv/ksm_checker.sv
dv/key_sequence_matcher_tb.sv
